// ===== sv/fqis_pkg.sv =====
// Shared types and constants for the indexed and searchable queue.
package fqis_pkg;

  // Fixed widths of the channel fields.
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LEN_W    = 5;

  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_READ   = 2'd2,
    OP_SEARCH = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_BADPOS = 3'd3,
    ST_MISS   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_scan;
    logic hit;
    logic last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== sv/fqis_if.sv =====
// Request and response channel interfaces of the queue.
interface fqis_req_if;
  logic                                valid;
  logic                                ready;
  fqis_pkg::op_e                       op;
  logic [fqis_pkg::VALUE_W-1:0]        value_in;
  logic [fqis_pkg::POS_W-1:0]          position_in;

  modport source (output valid, op, value_in, position_in, input ready);
  modport sink   (input valid, op, value_in, position_in, output ready);
endinterface

interface fqis_rsp_if;
  logic                                valid;
  logic                                ready;
  fqis_pkg::status_e                   status;
  logic [fqis_pkg::VALUE_W-1:0]        value_out;
  logic [fqis_pkg::POS_W-1:0]          position_out;
  logic [fqis_pkg::LEN_W-1:0]          length;
  logic                                is_empty;
  logic [fqis_pkg::VALUE_W-1:0]        front_word;

  modport source (output valid, status, value_out, position_out, length, is_empty, front_word,
                  input ready);
  modport sink   (input valid, status, value_out, position_out, length, is_empty, front_word,
                  output ready);
endinterface

// ===== sv/fqis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fqis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fqis_ctrl.sv =====
// Sequencing state machine of the queue.
module fqis_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  fqis_pkg::dp_sts_t   sts_i,
  output fqis_pkg::ctrl_cmd_t cmd_o
);

  fqis_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fqis_pkg::S_IDLE: begin
        if (req_valid_i) begin
          state_d = sts_i.start_scan ? fqis_pkg::S_SCAN : fqis_pkg::S_FINISH;
        end
      end
      fqis_pkg::S_SCAN: begin
        if (sts_i.hit || sts_i.last) begin
          state_d = fqis_pkg::S_FINISH;
        end
      end
      fqis_pkg::S_FINISH: begin
        if (sts_i.out_free) begin
          state_d = fqis_pkg::S_IDLE;
        end
      end
      default: state_d = fqis_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o   = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      fqis_pkg::S_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.accept = req_valid_i;
      end
      fqis_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      fqis_pkg::S_FINISH: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fqis_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/fqis_dp.sv =====
// Datapath of the queue: ring pointers, entry RAM, scan counter and result register.
module fqis_dp #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fqis_pkg::ctrl_cmd_t               cmd_i,
  output fqis_pkg::dp_sts_t                 sts_o,
  input  fqis_pkg::op_e                     op_i,
  input  logic [fqis_pkg::VALUE_W-1:0]      value_i,
  input  logic [fqis_pkg::POS_W-1:0]        position_i,
  input  logic                              rsp_ready_i,
  output logic                              rsp_valid_o,
  output fqis_pkg::status_e                 status_o,
  output logic [fqis_pkg::VALUE_W-1:0]      value_o,
  output logic [fqis_pkg::POS_W-1:0]        position_o,
  output logic [fqis_pkg::LEN_W-1:0]        length_o,
  output logic                              is_empty_o,
  output logic [fqis_pkg::VALUE_W-1:0]      front_word_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > fqis_pkg::POS_W) ? CW : fqis_pkg::POS_W;
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // Adds an offset below DEPTH to a ring index and wraps once.
  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_A) begin
      sum = sum - DEPTH_A;
    end
    return sum[AW-1:0];
  endfunction

  // Control registers.
  logic [AW-1:0]     head_q, head_d;
  logic [AW-1:0]     tail_q, tail_d;
  logic [CW-1:0]     count_q, count_d;
  logic              out_valid_q, out_valid_d;

  // Payload registers.
  logic [DATA_WIDTH-1:0]          front_q, front_d;
  logic [DATA_WIDTH-1:0]          val_q, val_d;
  logic [AW-1:0]                  k_q, k_d;
  fqis_pkg::status_e              res_status_q, res_status_d;
  logic [DATA_WIDTH-1:0]          res_val_q, res_val_d;
  logic [fqis_pkg::POS_W-1:0]     res_pos_q, res_pos_d;
  logic                           res_ram_q, res_ram_d;
  logic                           front_ram_q, front_ram_d;
  fqis_pkg::status_e              out_status_q, out_status_d;
  logic [fqis_pkg::VALUE_W-1:0]   out_value_q, out_value_d;
  logic [fqis_pkg::POS_W-1:0]     out_pos_q, out_pos_d;
  logic [fqis_pkg::LEN_W-1:0]     out_len_q, out_len_d;
  logic                           out_empty_q, out_empty_d;
  logic [fqis_pkg::VALUE_W-1:0]   out_front_q, out_front_d;

  // RAM port signals.
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic [DATA_WIDTH-1:0] val_w;
  logic                  count_zero;
  logic                  full;
  logic [PW-1:0]         pos_ext;
  logic                  pos_bad;
  logic [AW-1:0]         pos_off;
  logic [AW-1:0]         head_nx;
  logic [AW-1:0]         tail_nx;
  logic [CW-1:0]         k_nx;
  logic                  hit;
  logic                  last;
  logic                  out_free;
  logic [DATA_WIDTH-1:0] front_new;

  fqis_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_fqis_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign val_w      = DATA_WIDTH'(value_i);
  assign count_zero = (count_q == '0);
  assign full       = (count_q == DEPTH_C);
  assign pos_ext    = PW'(position_i);
  assign pos_bad    = (pos_ext == '0) || (pos_ext > PW'(count_q));
  assign pos_off    = AW'(pos_ext - PW'(1));
  assign head_nx    = ring_add(head_q, AW'(1));
  assign tail_nx    = ring_add(tail_q, AW'(1));
  assign k_nx       = CW'(k_q) + CW'(1);
  assign hit        = (ram_rdata == val_q);
  assign last       = (k_nx == count_q);
  assign out_free   = !out_valid_q || rsp_ready_i;
  assign front_new  = front_ram_q ? ram_rdata : front_q;

  assign sts_o.start_scan = (op_i == fqis_pkg::OP_SEARCH) && !count_zero;
  assign sts_o.hit        = hit;
  assign sts_o.last       = last;
  assign sts_o.out_free   = out_free;

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    front_d      = front_q;
    val_d        = val_q;
    k_d          = k_q;
    res_status_d = res_status_q;
    res_val_d    = res_val_q;
    res_pos_d    = res_pos_q;
    res_ram_d    = res_ram_q;
    front_ram_d  = front_ram_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_pos_d    = out_pos_q;
    out_len_d    = out_len_q;
    out_empty_d  = out_empty_q;
    out_front_d  = out_front_q;
    ram_we       = 1'b0;
    ram_waddr    = tail_q;
    ram_wdata    = val_w;
    ram_re       = 1'b0;
    ram_raddr    = head_q;

    if (cmd_i.accept) begin
      val_d        = val_w;
      k_d          = '0;
      res_status_d = fqis_pkg::ST_OK;
      res_val_d    = '0;
      res_pos_d    = '0;
      res_ram_d    = 1'b0;
      front_ram_d  = 1'b0;
      unique case (op_i)
        fqis_pkg::OP_ENQ: begin
          if (full) begin
            res_status_d = fqis_pkg::ST_FULL;
          end else begin
            ram_we  = 1'b1;
            tail_d  = tail_nx;
            count_d = count_q + CW'(1);
            if (count_zero) begin
              front_d = val_w;
            end
          end
        end
        fqis_pkg::OP_DEQ: begin
          if (count_zero) begin
            res_status_d = fqis_pkg::ST_EMPTY;
          end else begin
            res_val_d = front_q;
            head_d    = head_nx;
            count_d   = count_q - CW'(1);
            // The new front word comes from the RAM unless the queue drains.
            if (count_q != CW'(1)) begin
              ram_re      = 1'b1;
              ram_raddr   = head_nx;
              front_ram_d = 1'b1;
            end
          end
        end
        fqis_pkg::OP_READ: begin
          if (pos_bad) begin
            res_status_d = fqis_pkg::ST_BADPOS;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ring_add(head_q, pos_off);
            res_ram_d = 1'b1;
          end
        end
        fqis_pkg::OP_SEARCH: begin
          res_status_d = fqis_pkg::ST_MISS;
          if (!count_zero) begin
            ram_re    = 1'b1;
            ram_raddr = head_q;
          end
        end
        default: begin
          res_status_d = fqis_pkg::ST_OK;
        end
      endcase
    end

    // One entry is compared per cycle; the next read is issued on a miss that is not the last entry.
    if (cmd_i.scan) begin
      if (hit) begin
        res_status_d = fqis_pkg::ST_OK;
        res_pos_d    = fqis_pkg::POS_W'(k_nx);
      end else if (!last) begin
        ram_re    = 1'b1;
        ram_raddr = ring_add(head_q, AW'(k_nx));
        k_d       = AW'(k_nx);
      end
    end

    if (cmd_i.finish) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_value_d  = fqis_pkg::VALUE_W'(res_ram_q ? ram_rdata : res_val_q);
      out_pos_d    = res_pos_q;
      out_len_d    = fqis_pkg::LEN_W'(count_q);
      out_empty_d  = count_zero;
      out_front_d  = count_zero ? '0 : fqis_pkg::VALUE_W'(front_new);
      front_d      = front_new;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q      <= front_d;
    val_q        <= val_d;
    k_q          <= k_d;
    res_status_q <= res_status_d;
    res_val_q    <= res_val_d;
    res_pos_q    <= res_pos_d;
    res_ram_q    <= res_ram_d;
    front_ram_q  <= front_ram_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_pos_q    <= out_pos_d;
    out_len_q    <= out_len_d;
    out_empty_q  <= out_empty_d;
    out_front_q  <= out_front_d;
  end

  assign rsp_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign value_o      = out_value_q;
  assign position_o   = out_pos_q;
  assign length_o     = out_len_q;
  assign is_empty_o   = out_empty_q;
  assign front_word_o = out_front_q;

endmodule

// ===== sv/fifo_queue_with_index_and_search_core.sv =====
// A response is registered in the finish state after its request transfer, or after the scan
// for a search that compares up to length entries; a stalled response adds its wait.
// A new request is taken only in the idle state, after the previous result has moved; the
// single read port of the entry RAM, scanned one entry per cycle, sets the search time.
// Reset (rst_ni low, asynchronous) empties the queue and clears the response valid;
// the entry RAM is not cleared, since only entries between head and tail are ever read.
module fifo_queue_with_index_and_search_core #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  fqis_req_if.sink   req_i,
  fqis_rsp_if.source rsp_o
);

  // The controller decides when a request transfer happens, when the search scan
  // advances and when the finished result moves into the response register.
  fqis_pkg::ctrl_cmd_t cmd;
  fqis_pkg::dp_sts_t   sts;
  logic                req_ready;

  fqis_ctrl u_fqis_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  assign req_i.ready = req_ready;

  // The datapath holds the ring pointers, the entry RAM and the response register.
  // The response register lets a new request transfer while the previous result
  // still waits for the consumer.
  fqis_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_fqis_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (req_i.op),
    .value_i      (req_i.value_in),
    .position_i   (req_i.position_in),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .status_o     (rsp_o.status),
    .value_o      (rsp_o.value_out),
    .position_o   (rsp_o.position_out),
    .length_o     (rsp_o.length),
    .is_empty_o   (rsp_o.is_empty),
    .front_word_o (rsp_o.front_word)
  );

endmodule

// ===== sv/fqis_checker.sv =====
// Port-level checker of the queue and its bind to the top level.
module fqis_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            rsp_valid_i,
  input logic                            rsp_ready_i,
  input fqis_pkg::status_e               rsp_status_i,
  input logic [fqis_pkg::VALUE_W-1:0]    rsp_value_i,
  input logic [fqis_pkg::POS_W-1:0]      rsp_position_i,
  input logic [fqis_pkg::LEN_W-1:0]      rsp_length_i,
  input logic                            rsp_is_empty_i,
  input logic [fqis_pkg::VALUE_W-1:0]    rsp_front_i
);

  // A stalled response stays valid and keeps its status, value, position and length.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_value_i) && $stable(rsp_position_i) && $stable(rsp_length_i))
    else $error("response changed while stalled");

  // The empty flag, the length and the front word agree.
  a_empty_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_is_empty_i == (rsp_length_i == '0))
      && (!rsp_is_empty_i || rsp_front_i == '0))
    else $error("empty flag, length and front word disagree");

  // A failed operation produces neither a word nor a position.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != fqis_pkg::ST_OK |-> rsp_value_i == '0
      && rsp_position_i == '0)
    else $error("failed operation returned data");

  // A dropped enqueue is reported only on a full queue.
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == fqis_pkg::ST_FULL |->
      rsp_length_i == fqis_pkg::LEN_W'(DEPTH))
    else $error("full status with queue not full");

endmodule

bind fifo_queue_with_index_and_search_core fqis_checker #(
  .DEPTH (DEPTH)
) u_fqis_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_status_i   (rsp_o.status),
  .rsp_value_i    (rsp_o.value_out),
  .rsp_position_i (rsp_o.position_out),
  .rsp_length_i   (rsp_o.length),
  .rsp_is_empty_i (rsp_o.is_empty),
  .rsp_front_i    (rsp_o.front_word)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the indexed and searchable queue core.
module tb_top;
  import fqis_pkg::*;

  // The instance under test uses the default ring size and word width.
  localparam int unsigned DEPTH            = 16;
  localparam int unsigned RANDOM_ITEMS     = 680;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  // A search may compare every stored entry, so allow well over a full scan for a stray
  // extra response to show up once the queue of expectations is empty.
  localparam int unsigned SETTLE_CYCLES    = 40;
  // The slowest correct run is roughly 700 items, each with its search scan, sender gap
  // and receiver stalls, plus the long hold; this limit leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT      = 400000;

  // Receiver behavior for one window of cycles.
  typedef enum int unsigned {
    RX_ALWAYS,
    RX_PATTERN,
    RX_COIN
  } rx_mode_e;

  // Which way the random operation mix pushes the fill level.
  typedef enum int unsigned {
    FILL_DRAIN,
    FILL_MIXED,
    FILL_GROW
  } fill_bias_e;

  // One response of the queue, field by field.
  typedef struct packed {
    status_e            status;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
    logic [LEN_W-1:0]   length;
    logic               is_empty;
    logic [VALUE_W-1:0] front;
  } queue_result_t;

  // Shadow copy of the ring. Every accepted request updates it and queues the
  // response the core must return; responses are then matched in order.
  class fifo_shadow;
    logic [VALUE_W-1:0] words [DEPTH];
    int unsigned        head;
    int unsigned        tail;
    int unsigned        count;
    queue_result_t      awaited [$];
    int unsigned        mismatches;

    function new();
      head       = 0;
      tail       = 0;
      count      = 0;
      mismatches = 0;
    endfunction

    function int unsigned ring_step(int unsigned idx);
      return (idx == DEPTH - 1) ? 0 : idx + 1;
    endfunction

    // Entry k places behind the front, k counted from 0.
    function logic [VALUE_W-1:0] word_at(int unsigned k);
      return words[(head + k) % DEPTH];
    endfunction

    function void note_request(op_e op, logic [VALUE_W-1:0] word, logic [POS_W-1:0] pos);
      queue_result_t r;
      int unsigned   k;
      bit            found;
      r        = '0;
      r.status = ST_OK;
      found    = 1'b0;
      case (op)
        OP_ENQ: begin
          if (count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            words[tail] = word;
            tail        = ring_step(tail);
            count++;
          end
        end
        OP_DEQ: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.value = words[head];
            head    = ring_step(head);
            count--;
          end
        end
        OP_READ: begin
          if (pos == 0 || pos > count) r.status = ST_BADPOS;
          else r.value = word_at(pos - 1);
        end
        default: begin
          // Only the first match counts; the value field stays zero on a hit.
          r.status = ST_MISS;
          for (k = 0; k < count; k++) begin
            if (!found && word_at(k) == word) begin
              found      = 1'b1;
              r.status   = ST_OK;
              r.position = POS_W'(k + 1);
            end
          end
        end
      endcase
      r.length   = LEN_W'(count);
      r.is_empty = (count == 0);
      r.front    = (count == 0) ? '0 : words[head];
      awaited.push_back(r);
    endfunction

    function void compare_field(string field, logic [VALUE_W-1:0] want,
                                logic [VALUE_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(queue_result_t got);
      queue_result_t want;
      if (awaited.size() == 0) begin
        $error("response transfer with no request outstanding");
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("status", VALUE_W'(want.status), VALUE_W'(got.status));
      compare_field("value_out", want.value, got.value);
      compare_field("position_out", VALUE_W'(want.position), VALUE_W'(got.position));
      compare_field("length", VALUE_W'(want.length), VALUE_W'(got.length));
      compare_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(got.is_empty));
      compare_field("front_word", want.front, got.front);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fqis_req_if req_if ();
  fqis_rsp_if rsp_if ();

  fifo_queue_with_index_and_search_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (VALUE_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  fifo_shadow shadow = new();

  // Set by the stimulus to ask the receiver for one long stall.
  bit long_hold_pending = 1'b0;

  // Words reused on purpose, so that searches often see duplicates and the
  // first-match rule gets exercised.
  logic [VALUE_W-1:0] word_pool [8];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both channels are observed at the rising edge, before any of this edge's
  // nonblocking updates land, so a transfer is seen exactly as the core sees it.
  // A request and a response in the same cycle never refer to each other, since the finish
  // state and the response register lie between a request transfer and its response.
  always @(posedge clk_i) begin : observe_transfers
    queue_result_t got;
    if (rst_ni === 1'b1) begin
      if (req_if.valid && req_if.ready) begin
        shadow.note_request(req_if.op, req_if.value_in, req_if.position_in);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got.status   = rsp_if.status;
        got.value    = rsp_if.value_out;
        got.position = rsp_if.position_out;
        got.length   = rsp_if.length;
        got.is_empty = rsp_if.is_empty;
        got.front    = rsp_if.front_word;
        shadow.check_response(got);
      end
    end
  end

  // Response side. The receiver switches between windows of full throughput,
  // a repeating stall pattern and coin-flip stalls, so that back-pressure hits
  // the core in every phase of its work. On request it holds off for a long
  // stretch, counted here, which lets the core fill up and stall its input.
  initial begin : response_sink
    rx_mode_e          mode;
    int unsigned       window;
    int unsigned       phase;
    logic [31:0]       pattern;
    rsp_if.ready <= 1'b0;
    mode    = RX_ALWAYS;
    window  = 0;
    phase   = 0;
    pattern = '1;
    forever begin
      @(posedge clk_i);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (window == 0) begin
          case ($urandom_range(0, 2))
            0:       mode = RX_ALWAYS;
            1:       mode = RX_PATTERN;
            default: mode = RX_COIN;
          endcase
          window  = $urandom_range(16, 96);
          pattern = $urandom;
        end
        window--;
        case (mode)
          RX_ALWAYS:  rsp_if.ready <= 1'b1;
          RX_PATTERN: rsp_if.ready <= pattern[phase % 32];
          default:    rsp_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
        phase++;
      end
    end
  end

  // Offers one request and returns at the edge where its transfer happens.
  // The caller either offers the next item or lowers valid in that same step.
  task automatic send_item(op_e op, logic [VALUE_W-1:0] word, logic [POS_W-1:0] pos);
    req_if.valid       <= 1'b1;
    req_if.op          <= op;
    req_if.value_in    <= word;
    req_if.position_in <= pos;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
  endtask

  // Lowers valid for the given number of cycles.
  task automatic idle_sender(int unsigned cycles);
    req_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Corner cases first: every operation on an empty queue, both extreme words,
  // a hit at the back and one near the back, a miss, filling to the brim, enqueue
  // when full and reads at position zero, at the last entry and past the end.
  task automatic run_directed();
    int unsigned k;
    send_item(OP_DEQ, '0, '0);
    send_item(OP_READ, '0, 5'd0);
    send_item(OP_READ, '1, 5'd1);
    send_item(OP_SEARCH, '0, '0);
    send_item(OP_ENQ, 32'h0000_0000, '0);
    send_item(OP_ENQ, 32'hFFFF_FFFF, 5'd31);
    send_item(OP_SEARCH, 32'hFFFF_FFFF, '0);
    send_item(OP_READ, '0, 5'd2);
    send_item(OP_SEARCH, 32'h1234_5678, '0);
    for (k = 0; k < DEPTH - 3; k++) send_item(OP_ENQ, $urandom, POS_W'($urandom_range(0, 31)));
    send_item(OP_ENQ, 32'hA5A5_5A5A, '0);
    send_item(OP_ENQ, 32'h5A5A_A5A5, '0);
    send_item(OP_READ, '0, 5'd16);
    send_item(OP_READ, '0, 5'd17);
    send_item(OP_READ, '0, 5'd31);
    send_item(OP_SEARCH, 32'hA5A5_5A5A, '0);
    send_item(OP_DEQ, '0, '0);
    idle_sender(1);
  endtask

  // Random traffic in bursts. The operation mix drifts between growing and
  // draining the queue so that the ring wraps and both the full and the empty
  // boundary are hit repeatedly. Reads mostly hit a valid position and searches
  // mostly look for a stored word; the rest probe the error paths.
  task automatic run_random(int unsigned total);
    int unsigned        sent;
    int unsigned        burst;
    int unsigned        roll;
    int unsigned        fill;
    int unsigned        enq_pct;
    int unsigned        deq_pct;
    bit                 hold_done;
    bit                 drain_done;
    fill_bias_e         bias;
    op_e                op;
    logic [VALUE_W-1:0] word;
    logic [POS_W-1:0]   pos;
    sent       = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    bias       = FILL_GROW;
    while (sent < total) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      // Once, keep offering a long burst while the receiver holds off.
      if (!hold_done && sent >= 200) begin
        long_hold_pending = 1'b1;
        hold_done         = 1'b1;
        burst             = 40;
      end
      for (int unsigned b = 0; b < burst && sent < total; b++) begin
        if (sent % 40 == 0) begin
          case ($urandom_range(0, 2))
            0:       bias = FILL_DRAIN;
            1:       bias = FILL_MIXED;
            default: bias = FILL_GROW;
          endcase
        end
        case (bias)
          FILL_DRAIN: begin enq_pct = 15; deq_pct = 45; end
          FILL_MIXED: begin enq_pct = 35; deq_pct = 25; end
          default:    begin enq_pct = 55; deq_pct = 15; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < enq_pct) op = OP_ENQ;
        else if (roll < enq_pct + deq_pct) op = OP_DEQ;
        else if (roll % 2 == 0) op = OP_READ;
        else op = OP_SEARCH;
        // The shadow may lag by the item just sent; that only skews the choice.
        fill = shadow.count;
        word = ($urandom_range(0, 9) < 4) ? word_pool[$urandom_range(0, 7)] : $urandom;
        pos  = POS_W'($urandom_range(0, 31));
        if (op == OP_READ && fill > 0 && $urandom_range(0, 4) != 0) begin
          pos = POS_W'($urandom_range(1, fill));
        end
        if (op == OP_SEARCH && fill > 0 && $urandom_range(0, 2) != 0) begin
          word = shadow.word_at($urandom_range(0, fill - 1));
        end
        send_item(op, word, pos);
        sent++;
      end
      // Once, stop sending until every response has come back.
      if (!drain_done && sent >= 450) begin
        drain_done = 1'b1;
        idle_sender(1);
        while (shadow.awaited.size() != 0) @(posedge clk_i);
      end else begin
        idle_sender($urandom_range(1, 8));
      end
    end
  endtask

  initial begin : stimulus
    req_if.valid       <= 1'b0;
    req_if.op          <= OP_ENQ;
    req_if.value_in    <= '0;
    req_if.position_in <= '0;
    rst_ni             <= 1'b0;
    word_pool[0] = 32'h0000_0000;
    word_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) word_pool[i] = $urandom;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    run_directed();
    run_random(RANDOM_ITEMS);

    // All requests are in; wait for the last responses, then a little longer
    // so that a stray extra response would still be caught.
    while (shadow.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.awaited.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Ends a hung run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fqis_pkg.sv
sv/fqis_if.sv
sv/fqis_ram.sv
sv/fqis_ctrl.sv
sv/fqis_dp.sv
sv/fifo_queue_with_index_and_search_core.sv
sv/fqis_checker.sv
dv/tb_top.sv
